// ===== rtl/fdec_pkg.sv =====
// Shared types and constants for the decimating FIR filter.
`default_nettype none

package fdec_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int INDEX_W  = 5;
  localparam int FACTOR_W = 5;
  localparam int PHASE_W  = 4;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 5'd2;
  localparam logic [FACTOR_W-1:0] FACTOR_MAX   = 5'd16;

  // Item kind codes.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAC  = 4'b0010,
    ST_LAST = 4'b0100,
    ST_WB   = 4'b1000
  } fdec_state_t;

  // Shared control for every cell in the row.
  typedef struct packed {
    logic rotate;  // whole ring moves one place (history and coefficient)
    logic shift;   // history moves one place, new sample enters cell 0
  } fdec_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/fir_decimator_unit.sv =====
// Top level of the decimating FIR filter: tap cell ring, shared MAC, sequencer.
// Timing: a sample transfer takes the sequencer through MAC, LAST and WB; a kept
//   sample's result enters the output register in WB once that register is free.
// Input: no new item is taken until the sequencer is back in IDLE, set by the single
//   MAC walking the ring of tap cells once per sample; one coefficient write per cycle while idle.
// Reset (rst, synchronous, active high): history, coefficients, phase clear; factor 2.
`default_nettype none

module fir_decimator_unit #(
  parameter int TAPS = 32
) (
  input  wire                                       clk,
  input  wire                                       rst,
  // configuration
  input  wire                                       cfg_wr_en,
  input  wire logic [fdec_pkg::FACTOR_W-1:0]        cfg_wr_data,
  // item channel
  input  wire                                       item_valid,
  output logic                                      item_stall,
  input  wire                                       kind,
  input  wire logic signed [fdec_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [fdec_pkg::INDEX_W-1:0]         coef_index,
  input  wire logic signed [fdec_pkg::SAMPLE_W-1:0] coef_value,
  // result channel
  output logic                                      result_valid,
  input  wire                                       result_stall,
  output logic signed [fdec_pkg::SAMPLE_W-1:0]      filtered
);

  localparam int CNT_W = $clog2(TAPS);

  fdec_pkg::fdec_state_t     state;
  fdec_pkg::fdec_state_t     state_next;
  fdec_pkg::fdec_cell_ctrl_t cell_ctrl;

  logic [CNT_W-1:0]                    cnt;
  logic [fdec_pkg::FACTOR_W-1:0]       decimation_factor;
  logic [fdec_pkg::FACTOR_W-1:0]       eff_factor;
  logic [fdec_pkg::PHASE_W-1:0]        phase;
  logic [fdec_pkg::PHASE_W-1:0]        phase_next;
  logic [fdec_pkg::FACTOR_W-1:0]       phase_inc;
  logic                                emit;

  logic item_xfer;
  logic sample_xfer;
  logic coef_xfer;
  logic out_free;

  logic signed [fdec_pkg::SAMPLE_W-1:0] hist_q [TAPS];
  logic signed [fdec_pkg::SAMPLE_W-1:0] coef_q [TAPS];
  logic signed [fdec_pkg::SAMPLE_W-1:0] mac_result;

  // Input side is open only between samples.
  assign item_stall  = (state != fdec_pkg::ST_IDLE);
  assign item_xfer   = item_valid & ~item_stall;
  assign sample_xfer = item_xfer & (kind == fdec_pkg::KIND_SAMPLE);
  assign coef_xfer   = item_xfer & (kind == fdec_pkg::KIND_COEF);
  assign out_free    = ~result_valid | ~result_stall;

  assign cell_ctrl.rotate = (state == fdec_pkg::ST_MAC);
  assign cell_ctrl.shift  = sample_xfer;

  // Ring of tap cells. Cell i takes from cell i-1; cell 0 takes the new
  // sample on a shift, or the last cell while the ring rotates past the MAC.
  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    logic signed [fdec_pkg::SAMPLE_W-1:0] prev_hist;
    logic signed [fdec_pkg::SAMPLE_W-1:0] prev_coef;
    logic                                 cell_we;

    if (i == 0) begin : g_head
      assign prev_hist = cell_ctrl.rotate ? hist_q[TAPS-1] : sample;
      assign prev_coef = coef_q[TAPS-1];
    end else begin : g_body
      assign prev_hist = hist_q[i-1];
      assign prev_coef = coef_q[i-1];
    end

    // Indexes at or above TAPS never match, so such writes are dropped.
    assign cell_we = coef_xfer & (32'(coef_index) == i);

    fdec_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (cell_ctrl),
      .coef_we    (cell_we),
      .coef_wdata (coef_value),
      .prev_hist  (prev_hist),
      .prev_coef  (prev_coef),
      .hist       (hist_q[i]),
      .coef       (coef_q[i])
    );
  end

  // MAC always looks at cell 0; after TAPS rotations every pair has passed
  // and the ring is back in its original order.
  fdec_mac #(
    .TAPS (TAPS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .clear  (sample_xfer),
    .mul_en (cell_ctrl.rotate),
    .coef   (coef_q[0]),
    .hist   (hist_q[0]),
    .result (mac_result)
  );

  // Effective factor: 0 acts as 1, above 16 clips to 16.
  always_comb begin
    if (decimation_factor == '0) begin
      eff_factor = fdec_pkg::FACTOR_W'(1);
    end else if (decimation_factor > fdec_pkg::FACTOR_MAX) begin
      eff_factor = fdec_pkg::FACTOR_MAX;
    end else begin
      eff_factor = decimation_factor;
    end
    phase_inc = fdec_pkg::FACTOR_W'(phase) + fdec_pkg::FACTOR_W'(1);
    if (phase_inc >= eff_factor) begin
      phase_next = '0;
    end else begin
      phase_next = phase_inc[fdec_pkg::PHASE_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      fdec_pkg::ST_IDLE: begin
        if (sample_xfer) state_next = fdec_pkg::ST_MAC;
      end
      fdec_pkg::ST_MAC: begin
        if (cnt == CNT_W'(TAPS - 1)) state_next = fdec_pkg::ST_LAST;
      end
      fdec_pkg::ST_LAST: begin
        state_next = fdec_pkg::ST_WB;
      end
      fdec_pkg::ST_WB: begin
        // decimated-away samples skip the output register
        if (!emit || out_free) state_next = fdec_pkg::ST_IDLE;
      end
      default: state_next = fdec_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= fdec_pkg::ST_IDLE;
      cnt               <= '0;
      phase             <= '0;
      emit              <= 1'b0;
      decimation_factor <= fdec_pkg::FACTOR_RESET;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        decimation_factor <= cfg_wr_data;
      end
      if (sample_xfer) begin
        cnt   <= '0;
        emit  <= (phase == '0);
        phase <= phase_next;
      end else if (state == fdec_pkg::ST_MAC) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // Output register: frees the input side while a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == fdec_pkg::ST_WB && emit && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == fdec_pkg::ST_WB && emit && out_free) begin
      filtered <= mac_result;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fdec_cell.sv =====
// One tap cell: holds a history sample and its coefficient.
`default_nettype none

module fdec_cell (
  input  wire                                       clk,
  input  wire                                       rst,
  input  wire fdec_pkg::fdec_cell_ctrl_t            ctrl,
  input  wire                                       coef_we,
  input  wire logic signed [fdec_pkg::SAMPLE_W-1:0] coef_wdata,
  input  wire logic signed [fdec_pkg::SAMPLE_W-1:0] prev_hist,
  input  wire logic signed [fdec_pkg::SAMPLE_W-1:0] prev_coef,
  output logic signed [fdec_pkg::SAMPLE_W-1:0]      hist,
  output logic signed [fdec_pkg::SAMPLE_W-1:0]      coef
);

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
      coef <= '0;
    end else if (ctrl.rotate) begin
      hist <= prev_hist;
      coef <= prev_coef;
    end else begin
      if (ctrl.shift) begin
        hist <= prev_hist;
      end
      if (coef_we) begin
        coef <= coef_wdata;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fdec_mac.sv =====
// Shared multiply-accumulate unit with Q1.15 round and saturate.
`default_nettype none

module fdec_mac #(
  parameter int TAPS = 32
) (
  input  wire                                       clk,
  input  wire                                       rst,
  input  wire                                       clear,
  input  wire                                       mul_en,
  input  wire logic signed [fdec_pkg::SAMPLE_W-1:0] coef,
  input  wire logic signed [fdec_pkg::SAMPLE_W-1:0] hist,
  output logic signed [fdec_pkg::SAMPLE_W-1:0]      result
);

  localparam int ACC_W = fdec_pkg::PROD_W + $clog2(TAPS);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(16384);
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO   = -ACC_W'(32768);

  logic signed [fdec_pkg::PROD_W-1:0] prod;
  logic                               prod_vld;
  logic signed [ACC_W-1:0]            acc;
  logic signed [ACC_W-1:0]            rnd;
  logic signed [ACC_W-1:0]            quo;

  always_ff @(posedge clk) begin
    prod <= coef * hist;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      acc      <= '0;
    end else if (clear) begin
      prod_vld <= 1'b0;
      acc      <= '0;
    end else begin
      prod_vld <= mul_en;
      if (prod_vld) begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  // Round half up, then floor shift back to Q1.15.
  always_comb begin
    rnd = acc + RND_HALF;
    quo = rnd >>> 15;
    if (quo > SAT_HI) begin
      result = SAT_HI[fdec_pkg::SAMPLE_W-1:0];
    end else if (quo < SAT_LO) begin
      result = SAT_LO[fdec_pkg::SAMPLE_W-1:0];
    end else begin
      result = quo[fdec_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

`default_nettype wire
